/* hw/rtl/gspot_pkg.sv */
// Shared types and constants for the gaussian spot model evaluator.
`timescale 1ns / 1ps
package gspot_pkg;

  localparam int unsigned MaxWidthDef      = 64;
  localparam int unsigned ExpTableDepthDef = 256;

  localparam int unsigned IdxW  = 12;
  localparam int unsigned WidW  = 7;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned CfgAw = 3;

  localparam logic [WidW-1:0] ImageWidthRst = 7'd7;
  localparam logic [15:0]     CenterRst     = 16'd3072;
  localparam logic [15:0]     SigmaRst      = 16'd4096;

  typedef enum logic [CfgAw-1:0] {
    CFG_IMAGE_WIDTH = 3'd0,
    CFG_CENTER_ROW  = 3'd1,
    CFG_CENTER_COL  = 3'd2,
    CFG_SIGMA_ROW   = 3'd3,
    CFG_SIGMA_COL   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [IdxW-1:0]    pixel_index;
    logic signed [31:0] amplitude;
    logic signed [31:0] background;
    logic               last_pixel;
  } req_t;

  typedef struct packed {
    logic signed [31:0] model_value;
    logic [15:0]        gauss_term;
    logic               saturated;
    logic               last_out;
  } res_t;

  // fields that ride along the pipeline untouched until the last stages
  typedef struct packed {
    logic signed [31:0] amplitude;
    logic signed [31:0] background;
    logic               last_pixel;
  } side_t;

endpackage

/* hw/rtl/gaussian_spot_model_eval_core.sv */
// Pipelined elliptical gaussian spot model: one pixel in, one model value out.
//
//  port group   dir  role
//  start/req    in   pixel request, taken when start_i high and busy_o low
//  done/res     out  model result, valid for one cycle while done_o is high
//  cfg_*        in   register write, index + data, taken when cfg_we_i high
//
// A new request is taken every cycle.
// The depth is set by the 12-step index divider and the 20-step ratio divider.
// busy_o stays low: the pipeline never stalls and the receiver cannot hold off.
// Reset clears the valid chain and the configuration registers; the exp table is constant.
`timescale 1ns / 1ps
module gaussian_spot_model_eval_core #(
  parameter int unsigned MAX_WIDTH       = gspot_pkg::MaxWidthDef,
  parameter int unsigned EXP_TABLE_DEPTH = gspot_pkg::ExpTableDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  gspot_pkg::req_t              req_i,
  output logic                         done_o,
  output gspot_pkg::res_t              res_o,
  input  logic                         cfg_we_i,
  input  logic [gspot_pkg::CfgAw-1:0]  cfg_idx_i,
  input  logic [gspot_pkg::CfgW-1:0]   cfg_data_i
);

  localparam int unsigned IW  = gspot_pkg::IdxW;
  localparam int unsigned WW  = gspot_pkg::WidW;
  localparam int unsigned QB  = 20;
  localparam int unsigned RW  = 34;
  localparam int unsigned TW  = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int unsigned PW  = 20 + TW;
  localparam int unsigned LAT = 40;
  localparam longint      Q30 = 64'sd1 <<< 30;

  typedef logic [16:0] tab_t [EXP_TABLE_DEPTH+1];

  // shift-subtract quotient of two nonnegative values, used only to build the table
  function automatic longint udiv(input longint num, input longint den);
    longint q, r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r <<< 1) | ((num >>> b) & 64'sd1);
      q = q <<< 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'sd1;
      end
    end
    return q;
  endfunction

  function automatic logic [16:0] exp_entry(input int unsigned k);
    longint z, term, sum;
    z    = udiv(longint'(k) <<< 30, 2 * longint'(EXP_TABLE_DEPTH));
    term = Q30;
    sum  = Q30;
    for (int i = 1; i <= 12; i++) begin
      term = udiv((term * z) >>> 30, longint'(i));
      if ((i & 1) != 0) sum = sum - term;
      else sum = sum + term;
    end
    if (sum < 0) sum = 0;
    for (int j = 0; j < 5; j++) begin
      sum = (sum * sum + (Q30 >>> 1)) >>> 30;
    end
    return 17'((sum + 64'sd8192) >>> 14);
  endfunction

  function automatic tab_t build_tab();
    tab_t t;
    for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
      t[k] = exp_entry(k);
    end
    return t;
  endfunction

  localparam tab_t ExpTab = build_tab();

  // ---------------- configuration
  logic [WW-1:0] width_q;
  logic [15:0]   crow_q, ccol_q, srow_q, scol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= gspot_pkg::ImageWidthRst;
      crow_q  <= gspot_pkg::CenterRst;
      ccol_q  <= gspot_pkg::CenterRst;
      srow_q  <= gspot_pkg::SigmaRst;
      scol_q  <= gspot_pkg::SigmaRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gspot_pkg::CFG_IMAGE_WIDTH: width_q <= cfg_data_i[WW-1:0];
        gspot_pkg::CFG_CENTER_ROW:  crow_q  <= cfg_data_i;
        gspot_pkg::CFG_CENTER_COL:  ccol_q  <= cfg_data_i;
        gspot_pkg::CFG_SIGMA_ROW:   srow_q  <= cfg_data_i;
        gspot_pkg::CFG_SIGMA_COL:   scol_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [WW-1:0] weff;
  always_comb begin
    weff = width_q;
    if (width_q == '0) weff = WW'(1);
    else if (32'(width_q) > MAX_WIDTH) weff = WW'(MAX_WIDTH);
  end

  logic [15:0] sr_eff, sc_eff;
  assign sr_eff = (srow_q == '0) ? 16'd1 : srow_q;
  assign sc_eff = (scol_q == '0) ? 16'd1 : scol_q;

  // sigma squares depend only on configuration
  logic [31:0] s2r_q, s2c_q;
  always_ff @(posedge clk_i) begin
    s2r_q <= sr_eff * sr_eff;
    s2c_q <= sc_eff * sc_eff;
  end

  assign busy_o = 1'b0;

  // ---------------- input register
  logic              in_v_q;
  gspot_pkg::req_t   in_q;
  gspot_pkg::side_t  in_side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_v_q <= 1'b0;
    else in_v_q <= start_i && !busy_o;
  end
  always_ff @(posedge clk_i) begin
    in_q <= req_i;
  end
  assign in_side = '{amplitude: in_q.amplitude, background: in_q.background,
                     last_pixel: in_q.last_pixel};

  // ---------------- index / width, one quotient bit per stage
  logic             dv_v_q   [IW];
  logic [IW-1:0]    dv_qd_q  [IW];
  logic [WW-1:0]    dv_rem_q [IW];
  gspot_pkg::side_t dv_side_q[IW];

  for (genvar k = 0; k < IW; k++) begin : g_div
    logic             v_in;
    logic [IW-1:0]    qd_in;
    logic [WW-1:0]    rem_in;
    gspot_pkg::side_t side_in;
    logic [WW:0]      trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in    = in_v_q;
      assign qd_in   = in_q.pixel_index;
      assign rem_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = dv_v_q[k-1];
      assign qd_in   = dv_qd_q[k-1];
      assign rem_in  = dv_rem_q[k-1];
      assign side_in = dv_side_q[k-1];
    end

    assign trial = {rem_in, qd_in[IW-1]};
    assign ge    = trial >= {1'b0, weff};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[k] <= 1'b0;
      else dv_v_q[k] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      dv_qd_q[k]   <= {qd_in[IW-2:0], ge};
      dv_rem_q[k]  <= ge ? WW'(trial - {1'b0, weff}) : trial[WW-1:0];
      dv_side_q[k] <= side_in;
    end
  end

  // ---------------- offsets squared
  logic signed [23:0] dr, dc;
  assign dr = $signed({2'b00, dv_qd_q[IW-1], 10'b0}) - $signed({8'b0, crow_q});
  assign dc = $signed({5'b0, dv_rem_q[IW-1], 10'b0}) + $signed(24'sd0)
              - $signed({8'b0, ccol_q});

  logic             sq_v_q;
  logic [43:0]      sq_d2r_q, sq_d2c_q;
  gspot_pkg::side_t sq_side_q;
  logic signed [47:0] dr2, dc2;
  assign dr2 = dr * dr;
  assign dc2 = dc * dc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sq_v_q <= 1'b0;
    else sq_v_q <= dv_v_q[IW-1];
  end
  always_ff @(posedge clk_i) begin
    sq_d2r_q  <= dr2[43:0];
    sq_d2c_q  <= dc2[43:0];
    sq_side_q <= dv_side_q[IW-1];
  end

  logic cap_r, cap_c;
  assign cap_r = sq_d2r_q >= {11'b0, s2r_q, 1'b0};
  assign cap_c = sq_d2c_q >= {11'b0, s2c_q, 1'b0};

  // ---------------- d2 * 2^19 / s2, one quotient bit per stage on both axes
  logic             rd_v_q    [QB];
  logic [RW-1:0]    rd_rr_q   [QB];
  logic [RW-1:0]    rd_rc_q   [QB];
  logic [QB-1:0]    rd_qr_q   [QB];
  logic [QB-1:0]    rd_qc_q   [QB];
  logic             rd_capr_q [QB];
  logic             rd_capc_q [QB];
  gspot_pkg::side_t rd_side_q [QB];

  for (genvar j = 0; j < QB; j++) begin : g_rdiv
    logic             v_in, capr_in, capc_in;
    logic [RW-1:0]    rr_in, rc_in;
    logic [QB-1:0]    qr_in, qc_in;
    gspot_pkg::side_t side_in;
    logic             ger, gec;

    if (j == 0) begin : g_first
      assign v_in    = sq_v_q;
      assign rr_in   = sq_d2r_q[RW-1:0];
      assign rc_in   = sq_d2c_q[RW-1:0];
      assign qr_in   = '0;
      assign qc_in   = '0;
      assign capr_in = cap_r;
      assign capc_in = cap_c;
      assign side_in = sq_side_q;
    end else begin : g_next
      assign v_in    = rd_v_q[j-1];
      assign rr_in   = {rd_rr_q[j-1][RW-2:0], 1'b0};
      assign rc_in   = {rd_rc_q[j-1][RW-2:0], 1'b0};
      assign qr_in   = rd_qr_q[j-1];
      assign qc_in   = rd_qc_q[j-1];
      assign capr_in = rd_capr_q[j-1];
      assign capc_in = rd_capc_q[j-1];
      assign side_in = rd_side_q[j-1];
    end

    assign ger = rr_in >= {2'b0, s2r_q};
    assign gec = rc_in >= {2'b0, s2c_q};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) rd_v_q[j] <= 1'b0;
      else rd_v_q[j] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      rd_rr_q[j]   <= ger ? rr_in - {2'b0, s2r_q} : rr_in;
      rd_rc_q[j]   <= gec ? rc_in - {2'b0, s2c_q} : rc_in;
      rd_qr_q[j]   <= {qr_in[QB-2:0], ger};
      rd_qc_q[j]   <= {qc_in[QB-2:0], gec};
      rd_capr_q[j] <= capr_in;
      rd_capc_q[j] <= capc_in;
      rd_side_q[j] <= side_in;
    end
  end

  // ---------------- exponent sum and table position
  logic [20:0] t_r, t_c;
  logic [21:0] e_sum;
  logic [PW-1:0] pos;
  logic [TW-1:0] ti_raw, ti;

  assign t_r   = rd_capr_q[QB-1] ? 21'h100000 : {1'b0, rd_qr_q[QB-1]};
  assign t_c   = rd_capc_q[QB-1] ? 21'h100000 : {1'b0, rd_qc_q[QB-1]};
  assign e_sum = {1'b0, t_r} + {1'b0, t_c};
  assign pos   = PW'(e_sum[19:0]) * PW'(EXP_TABLE_DEPTH);
  assign ti_raw = pos[PW-1:20];
  assign ti    = (32'(ti_raw) > EXP_TABLE_DEPTH - 1) ? TW'(EXP_TABLE_DEPTH - 1) : ti_raw;

  logic             sm_v_q, sm_zero_q;
  logic [TW-1:0]    sm_ti_q;
  logic [15:0]      sm_f_q;
  gspot_pkg::side_t sm_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sm_v_q <= 1'b0;
    else sm_v_q <= rd_v_q[QB-1];
  end
  always_ff @(posedge clk_i) begin
    sm_zero_q <= e_sum >= 22'h100000;
    sm_ti_q   <= ti;
    sm_f_q    <= pos[19:4];
    sm_side_q <= rd_side_q[QB-1];
  end

  // ---------------- table read
  logic             tb_v_q, tb_zero_q;
  logic [16:0]      tb_a_q, tb_diff_q;
  logic [15:0]      tb_f_q;
  gspot_pkg::side_t tb_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tb_v_q <= 1'b0;
    else tb_v_q <= sm_v_q;
  end
  always_ff @(posedge clk_i) begin
    tb_a_q    <= ExpTab[sm_ti_q];
    tb_diff_q <= ExpTab[sm_ti_q] - ExpTab[sm_ti_q + TW'(1)];
    tb_f_q    <= sm_f_q;
    tb_zero_q <= sm_zero_q;
    tb_side_q <= sm_side_q;
  end

  // ---------------- interpolation product
  logic             ip_v_q, ip_zero_q;
  logic [16:0]      ip_a_q;
  logic [32:0]      ip_prod_q;
  gspot_pkg::side_t ip_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ip_v_q <= 1'b0;
    else ip_v_q <= tb_v_q;
  end
  always_ff @(posedge clk_i) begin
    ip_prod_q <= tb_diff_q * tb_f_q;
    ip_a_q    <= tb_a_q;
    ip_zero_q <= tb_zero_q;
    ip_side_q <= tb_side_q;
  end

  // ---------------- gaussian value
  logic [16:0]      g_full;
  logic             g_v_q;
  logic [15:0]      g_q;
  gspot_pkg::side_t g_side_q;

  assign g_full = ip_a_q - ip_prod_q[32:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g_v_q <= 1'b0;
    else g_v_q <= ip_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (ip_zero_q) g_q <= '0;
    else if (g_full[16]) g_q <= 16'hFFFF;
    else g_q <= g_full[15:0];
    g_side_q <= ip_side_q;
  end

  // ---------------- amplitude product
  logic               am_v_q;
  logic signed [48:0] am_p_q;
  logic [15:0]        am_g_q;
  gspot_pkg::side_t   am_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) am_v_q <= 1'b0;
    else am_v_q <= g_v_q;
  end
  always_ff @(posedge clk_i) begin
    am_p_q    <= g_side_q.amplitude * $signed({1'b0, g_q});
    am_g_q    <= g_q;
    am_side_q <= g_side_q;
  end

  // ---------------- round, add background, saturate
  logic signed [48:0] rnd_full;
  logic signed [33:0] val;
  logic               sat_hi, sat_lo;

  assign rnd_full = (am_p_q + 49'sd32768) >>> 16;
  assign val      = 34'(rnd_full) + 34'(am_side_q.background);
  assign sat_hi   = val > 34'sd2147483647;
  assign sat_lo   = val < -34'sd2147483648;

  logic            done_q;
  gspot_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= am_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (sat_hi) res_q.model_value <= 32'sh7FFFFFFF;
    else if (sat_lo) res_q.model_value <= 32'sh80000000;
    else res_q.model_value <= val[31:0];
    res_q.gauss_term <= am_g_q;
    res_q.saturated  <= sat_hi || sat_lo;
    res_q.last_out   <= am_side_q.last_pixel;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // ---------------- assertions
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q |-> ##(LAT - 1) done_o)
    else $error("result strobe out of step with requests");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.saturated |->
      (res_o.model_value == 32'sh7FFFFFFF) || (res_o.model_value == 32'sh80000000))
    else $error("saturation flag without clipped value");

  a_zero_gauss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sm_v_q && sm_zero_q |-> ##3 (g_q == '0))
    else $error("exponent past range gave nonzero gaussian");

endmodule
